[src/fsr_pkg.sv]
// Shared types, codes and constants for the scratchpad residency tracker.
`timescale 1ns / 1ps

package fsr_pkg;

   // field widths fixed by the interface
   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned BYTES_W    = 21;
   localparam int unsigned OUT_CNT_W  = 5;
   localparam int unsigned MAXE_W     = 5;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned ENTRY_W    = ADDR_W + BYTES_W;

   // bound on the footprint sum, 2**20 bytes; the 21-bit byte fields can express more
   localparam logic [BYTES_W-1:0] MAX_BYTES = BYTES_W'(1048576);

   // defaults
   localparam int unsigned DEF_MAX_SLOTS = 16;
   localparam logic [BYTES_W-1:0] CAP_RESET  = BYTES_W'(4096);
   localparam logic [MAXE_W-1:0]  MAXE_RESET = MAXE_W'(16);
   localparam logic               IGN_RESET  = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ENTRIES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IGNORE      = 2'd2;

   typedef enum logic [1:0] {
      ST_HIT     = 2'd0,
      ST_LOADED  = 2'd1,
      ST_IGNORED = 2'd2,
      ST_ERROR   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_EVICT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [BYTES_W-1:0] capacity;
      logic [MAXE_W-1:0]  max_entries;
      logic               ignore_oversized;
   } cfg_type;

endpackage

[src/fsr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fsr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/fsr_csr.sv]
// Configuration registers of the residency tracker.
`timescale 1ns / 1ps

module fsr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fsr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fsr_pkg::BYTES_W-1:0]         csr_wdata,
   output fsr_pkg::cfg_type                    cfg
);

   logic [fsr_pkg::BYTES_W-1:0] cap_ff,  cap_in;
   logic [fsr_pkg::MAXE_W-1:0]  maxe_ff, maxe_in;
   logic                        ign_ff,  ign_in;

   // always able to take a write
   assign csr_ready = 1'b1;

   // decode the register index
   always_comb begin
      cap_in  = cap_ff;
      maxe_in = maxe_ff;
      ign_in  = ign_ff;
      if (csr_valid) begin
         case (csr_index)
            fsr_pkg::CSR_CAPACITY:    cap_in  = csr_wdata;
            fsr_pkg::CSR_MAX_ENTRIES: maxe_in = csr_wdata[fsr_pkg::MAXE_W-1:0];
            fsr_pkg::CSR_IGNORE:      ign_in  = csr_wdata[0];
            default: begin
               cap_in = cap_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= fsr_pkg::CAP_RESET;
         maxe_ff <= fsr_pkg::MAXE_RESET;
         ign_ff  <= fsr_pkg::IGN_RESET;
      end else begin
         cap_ff  <= cap_in;
         maxe_ff <= maxe_in;
         ign_ff  <= ign_in;
      end
   end

   assign cfg.capacity         = cap_ff;
   assign cfg.max_entries      = maxe_ff;
   assign cfg.ignore_oversized = ign_ff;

endmodule

[src/fsr_ctrl.sv]
// Sequencer: searches the resident ring, inserts misses and evicts oldest entries.
`timescale 1ns / 1ps

module fsr_ctrl #(
   parameter int unsigned MAX_SLOTS = fsr_pkg::DEF_MAX_SLOTS,
   localparam int unsigned SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fsr_pkg::cfg_type                    cfg,
   input  logic                                start,
   output logic                                busy,
   input  logic [fsr_pkg::ADDR_W-1:0]          req_func_address,
   input  logic [fsr_pkg::BYTES_W-1:0]         req_func_bytes,
   output logic                                ram_rd_en,
   output logic [SLOT_W-1:0]                   ram_rd_addr,
   input  logic [fsr_pkg::ENTRY_W-1:0]         ram_rd_data,
   output logic                                ram_wr_en,
   output logic [SLOT_W-1:0]                   ram_wr_addr,
   output logic [fsr_pkg::ENTRY_W-1:0]         ram_wr_data,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic [fsr_pkg::OUT_CNT_W-1:0]       rsp_evicted_count,
   output logic [fsr_pkg::OUT_CNT_W-1:0]       rsp_entries_held,
   output logic [fsr_pkg::BYTES_W-1:0]         rsp_bytes_used
);

   // the count sits one above the slot count while an insert waits on its drop
   localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 2);
   localparam int unsigned SUM_W = SLOT_W + 1;
   localparam int unsigned LIM_W = ((CNT_W > fsr_pkg::MAXE_W) ? CNT_W : fsr_pkg::MAXE_W) + 1;
   localparam int unsigned USED_W = fsr_pkg::BYTES_W + 1;

   // ring position: base plus offset, wrapped once
   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                  input logic [CNT_W-1:0]  offs);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offs);
      if (sum >= SUM_W'(MAX_SLOTS)) begin
         sum = sum - SUM_W'(MAX_SLOTS);
      end
      return sum[SLOT_W-1:0];
   endfunction

   fsr_pkg::state_type          state_ff, state_in;
   fsr_pkg::status_type         status_ff, status_in;
   logic [fsr_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic [fsr_pkg::BYTES_W-1:0] bytes_ff, bytes_in;
   logic [CNT_W-1:0]            evict_ff, evict_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [USED_W-1:0]           used_ff, used_in;
   logic [SLOT_W-1:0]           oldest_ff, oldest_in;
   logic [CNT_W-1:0]            age_ff, age_in;
   logic                        drop_ff, drop_in;
   logic                        ins_ff, ins_in;
   logic [SLOT_W-1:0]           wslot_ff, wslot_in;

   logic                        accept;
   logic                        oversized;
   logic [LIM_W-1:0]            limit;
   logic [fsr_pkg::BYTES_W-1:0] miss_bytes;
   logic                        miss_drop;
   logic                        miss_ins;
   logic                        miss_empty_zero;
   logic                        hit;
   logic                        last_age;
   logic                        miss_now;
   logic [fsr_pkg::BYTES_W-1:0] old_bytes;
   logic                        drop_now;

   assign accept    = start && (state_ff == fsr_pkg::S_IDLE);
   assign oversized = req_func_bytes > cfg.capacity;

   // effective table limit
   assign limit = (LIM_W'(cfg.max_entries) < LIM_W'(MAX_SLOTS)) ?
                  LIM_W'(cfg.max_entries) : LIM_W'(MAX_SLOTS);

   // miss decisions from the entry count before the step
   assign miss_bytes      = (state_ff == fsr_pkg::S_IDLE) ? req_func_bytes : bytes_ff;
   assign miss_drop       = (LIM_W'(count_ff) + LIM_W'(1) > limit) && (count_ff != '0);
   assign miss_empty_zero = (limit == '0) && (count_ff == '0);
   assign miss_ins        = !((limit == '0) && (count_ff <= CNT_W'(1)));

   // search compare on the returned entry
   assign hit      = ram_rd_data[fsr_pkg::ENTRY_W-1:fsr_pkg::BYTES_W] == addr_ff;
   assign last_age = age_ff == (count_ff - CNT_W'(1));

   // a miss is known on accept of an empty ring or at the last search compare
   assign miss_now = (accept && !oversized && (count_ff == '0)) ||
                     ((state_ff == fsr_pkg::S_SEARCH) && !hit && last_age);

   // eviction step on the oldest entry's footprint
   assign old_bytes = ram_rd_data[fsr_pkg::BYTES_W-1:0];
   assign drop_now  = drop_ff ||
                      ((used_ff > USED_W'(cfg.capacity)) && (count_ff != '0));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fsr_pkg::S_IDLE: begin
            if (accept) begin
               if (oversized) begin
                  state_in = fsr_pkg::S_RESP;
               end else if (count_ff == '0) begin
                  state_in = fsr_pkg::S_EVICT;
               end else begin
                  state_in = fsr_pkg::S_SEARCH;
               end
            end
         end
         fsr_pkg::S_SEARCH: begin
            if (hit) begin
               state_in = fsr_pkg::S_RESP;
            end else if (last_age) begin
               state_in = fsr_pkg::S_EVICT;
            end
         end
         fsr_pkg::S_EVICT: begin
            if (!drop_now) begin
               state_in = fsr_pkg::S_RESP;
            end
         end
         fsr_pkg::S_RESP: begin
            state_in = fsr_pkg::S_IDLE;
         end
         default: begin
            state_in = fsr_pkg::S_IDLE;
         end
      endcase
   end

   // datapath updates
   always_comb begin
      status_in = status_ff;
      addr_in   = addr_ff;
      bytes_in  = bytes_ff;
      evict_in  = evict_ff;
      count_in  = count_ff;
      used_in   = used_ff;
      oldest_in = oldest_ff;
      age_in    = age_ff;
      drop_in   = drop_ff;
      ins_in    = ins_ff;
      wslot_in  = wslot_ff;

      // latch the request
      if (accept) begin
         addr_in  = req_func_address;
         bytes_in = req_func_bytes;
         evict_in = '0;
         age_in   = '0;
         drop_in  = 1'b0;
         ins_in   = 1'b0;
         if (oversized) begin
            status_in = cfg.ignore_oversized ? fsr_pkg::ST_IGNORED : fsr_pkg::ST_ERROR;
         end
      end

      // advance the search
      if ((state_ff == fsr_pkg::S_SEARCH) && !hit && !last_age) begin
         age_in = age_ff + CNT_W'(1);
      end
      if ((state_ff == fsr_pkg::S_SEARCH) && hit) begin
         status_in = fsr_pkg::ST_HIT;
      end

      // insert as newest; the write itself waits for the response cycle
      if (miss_now) begin
         status_in = fsr_pkg::ST_LOADED;
         drop_in   = miss_drop;
         ins_in    = miss_ins;
         wslot_in  = slot_add(oldest_ff, count_ff);
         evict_in  = miss_empty_zero ? CNT_W'(1) : '0;
         if (miss_ins) begin
            count_in = count_ff + CNT_W'(1);
            used_in  = used_ff + USED_W'(miss_bytes);
         end
      end

      // drop the oldest entry
      if ((state_ff == fsr_pkg::S_EVICT) && drop_now) begin
         drop_in   = 1'b0;
         used_in   = used_ff - USED_W'(old_bytes);
         count_in  = count_ff - CNT_W'(1);
         oldest_in = slot_add(oldest_ff, CNT_W'(1));
         evict_in  = evict_ff + CNT_W'(1);
      end
   end

   // memory control and handshake outputs
   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = oldest_ff;
      ram_wr_en   = 1'b0;
      busy        = 1'b1;
      rsp_valid   = 1'b0;
      case (state_ff)
         fsr_pkg::S_IDLE: begin
            busy      = 1'b0;
            ram_rd_en = accept;
         end
         fsr_pkg::S_SEARCH: begin
            ram_rd_en = 1'b1;
            if (!last_age) begin
               ram_rd_addr = slot_add(oldest_ff, age_ff + CNT_W'(1));
            end
         end
         fsr_pkg::S_EVICT: begin
            ram_rd_en   = drop_now;
            ram_rd_addr = slot_add(oldest_ff, CNT_W'(1));
         end
         fsr_pkg::S_RESP: begin
            rsp_valid = 1'b1;
            ram_wr_en = ins_ff;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign ram_wr_addr = wslot_ff;
   assign ram_wr_data = {addr_ff, bytes_ff};

   assign rsp_status        = status_ff;
   assign rsp_evicted_count = fsr_pkg::OUT_CNT_W'(evict_ff);
   assign rsp_entries_held  = fsr_pkg::OUT_CNT_W'(count_ff);
   assign rsp_bytes_used    = used_ff[fsr_pkg::BYTES_W-1:0];

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fsr_pkg::S_IDLE;
         count_ff  <= '0;
         used_ff   <= '0;
         oldest_ff <= '0;
         drop_ff   <= 1'b0;
         ins_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         used_ff   <= used_in;
         oldest_ff <= oldest_in;
         drop_ff   <= drop_in;
         ins_ff    <= ins_in;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      addr_ff   <= addr_in;
      bytes_ff  <= bytes_in;
      evict_ff  <= evict_in;
      age_ff    <= age_in;
      wslot_ff  <= wslot_in;
   end

   // between requests the ring never holds more than its slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fsr_pkg::S_IDLE) |-> (count_ff <= CNT_W'(MAX_SLOTS)))
      else $error("entry count above slot count");

   // between requests the footprint sum fits the byte field
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fsr_pkg::S_IDLE) |-> (used_ff <= USED_W'(fsr_pkg::MAX_BYTES)))
      else $error("bytes used out of range when idle");

   // search only compares live entries
   a_search_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fsr_pkg::S_SEARCH) |-> (age_ff < count_ff))
      else $error("search beyond resident entries");

   // a drop always removes a resident entry
   a_drop_live: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == fsr_pkg::S_EVICT) && drop_now) |-> (count_ff != '0))
      else $error("eviction on an empty ring");

   // a finished request leaves the block idle for the next one
   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("response not followed by idle");

endmodule

[src/fifo_scratchpad_residency_top.sv]
// Top level of the FIFO scratchpad residency tracker.
`timescale 1ns / 1ps

// Usage
//   Request: drive req_func_address and req_func_bytes with start high; the
//   request is taken at a clock edge where start is high and busy is low.
//   busy stays high until the response cycle has passed.
//   Response: rsp_valid is high for exactly one cycle with rsp_status,
//   rsp_evicted_count, rsp_entries_held and rsp_bytes_used. The receiver
//   cannot hold it off; nothing waits on it.
//   Configuration: csr_valid/csr_ready with csr_index (0 capacity, 1 table
//   limit, 2 oversize mode) and csr_wdata; csr_ready is always high. Write
//   only while busy is low.
// Timing
//   Oversized request: response in the cycle after accept. Otherwise the
//   ring is searched first, one ring entry compared per cycle through the
//   entry memory's read port, stopping at a hit. For a miss, the eviction
//   state then drops oldest entries one at a time, as the table limit and
//   the capacity require, before the response.
// Reset
//   Synchronous, active high: the ring is emptied and the registers take
//   their defaults (4096 bytes, 16 entries, oversized ignored). The entry
//   memory itself is not cleared and needs no clearing pass.

module fifo_scratchpad_residency_top #(
   parameter int unsigned MAX_SLOTS = fsr_pkg::DEF_MAX_SLOTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [fsr_pkg::ADDR_W-1:0]          req_func_address,
   input  logic [fsr_pkg::BYTES_W-1:0]         req_func_bytes,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic [fsr_pkg::OUT_CNT_W-1:0]       rsp_evicted_count,
   output logic [fsr_pkg::OUT_CNT_W-1:0]       rsp_entries_held,
   output logic [fsr_pkg::BYTES_W-1:0]         rsp_bytes_used,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fsr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fsr_pkg::BYTES_W-1:0]         csr_wdata
);

   localparam int unsigned SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   fsr_pkg::cfg_type             cfg;
   logic                         ram_rd_en;
   logic [SLOT_W-1:0]            ram_rd_addr;
   logic [fsr_pkg::ENTRY_W-1:0]  ram_rd_data;
   logic                         ram_wr_en;
   logic [SLOT_W-1:0]            ram_wr_addr;
   logic [fsr_pkg::ENTRY_W-1:0]  ram_wr_data;

   // configuration registers
   fsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // resident entries: address and footprint per slot
   fsr_ram #(
      .WIDTH (fsr_pkg::ENTRY_W),
      .DEPTH (MAX_SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // search, insert and evict sequencer
   fsr_ctrl #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .start             (start),
      .busy              (busy),
      .req_func_address  (req_func_address),
      .req_func_bytes    (req_func_bytes),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_evicted_count (rsp_evicted_count),
      .rsp_entries_held  (rsp_entries_held),
      .rsp_bytes_used    (rsp_bytes_used)
   );

endmodule

[tb/testbench.sv]
// Self-checking testbench for the FIFO scratchpad residency tracker.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned SLOTS        = fsr_pkg::DEF_MAX_SLOTS;
   localparam int unsigned LIMIT_CYCLES = 400000;
   localparam int unsigned RANDOM_GOAL  = 1850;
   localparam int unsigned MAX_FOOT     = 1048576;

   // one response as the block reports it
   typedef struct {
      fsr_pkg::status_type                status;
      logic [fsr_pkg::OUT_CNT_W-1:0]      evicted;
      logic [fsr_pkg::OUT_CNT_W-1:0]      held;
      logic [fsr_pkg::BYTES_W-1:0]        used;
   } outcome_type;

   // one line of the directed plan: a register write or a request
   typedef struct {
      bit                                 is_write;
      logic [fsr_pkg::CSR_IDX_W-1:0]      reg_index;
      logic [fsr_pkg::BYTES_W-1:0]        reg_data;
      logic [fsr_pkg::ADDR_W-1:0]         addr;
      logic [fsr_pkg::BYTES_W-1:0]        nbytes;
      bit                                 typed;
      outcome_type                        want;
   } plan_row_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [fsr_pkg::ADDR_W-1:0]    req_func_address;
   logic [fsr_pkg::BYTES_W-1:0]   req_func_bytes;
   logic                          rsp_valid;
   logic [1:0]                    rsp_status;
   logic [fsr_pkg::OUT_CNT_W-1:0] rsp_evicted_count;
   logic [fsr_pkg::OUT_CNT_W-1:0] rsp_entries_held;
   logic [fsr_pkg::BYTES_W-1:0]   rsp_bytes_used;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [fsr_pkg::CSR_IDX_W-1:0] csr_index;
   logic [fsr_pkg::BYTES_W-1:0]   csr_wdata;

   // predictor copy of the resident ring and the registers
   logic [fsr_pkg::ADDR_W-1:0] ring_addr [SLOTS];
   int unsigned                ring_bytes [SLOTS];
   int unsigned                ring_head;
   int unsigned                ring_count;
   int unsigned                ring_used;
   int unsigned                cfg_capacity;
   int unsigned                cfg_limit;
   bit                         cfg_ignore;

   outcome_type  pending_outcomes [$];
   plan_row_type plan [$];
   int unsigned  mismatch_count;

   fifo_scratchpad_residency_top DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func_address  (req_func_address),
      .req_func_bytes    (req_func_bytes),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_evicted_count (rsp_evicted_count),
      .rsp_entries_held  (rsp_entries_held),
      .rsp_bytes_used    (rsp_bytes_used),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #2 clock = ~clock;

   // an all-zero response
   function automatic outcome_type blank_outcome();
      outcome_type res;
      res.status  = fsr_pkg::ST_HIT;
      res.evicted = '0;
      res.held    = '0;
      res.used    = '0;
      return res;
   endfunction

   // an empty plan line
   function automatic plan_row_type blank_row();
      plan_row_type row;
      row.is_write  = 1'b0;
      row.reg_index = fsr_pkg::CSR_CAPACITY;
      row.reg_data  = '0;
      row.addr      = '0;
      row.nbytes    = '0;
      row.typed     = 1'b0;
      row.want      = blank_outcome();
      return row;
   endfunction

   // drop the oldest resident, if any
   function automatic void retire_oldest();
      if (ring_count != 0) begin
         ring_used = ring_used - ring_bytes[ring_head];
         ring_head = (ring_head + 1) % SLOTS;
         ring_count--;
      end
   endfunction

   // advance the residency state by one request and return its response
   function automatic outcome_type predict_residency(
         input logic [fsr_pkg::ADDR_W-1:0]  addr,
         input logic [fsr_pkg::BYTES_W-1:0] nbytes);
      outcome_type res;
      int unsigned lim;
      int unsigned ev;
      int unsigned slot;
      bit          found;
      lim   = (cfg_limit < SLOTS) ? cfg_limit : SLOTS;
      ev    = 0;
      found = 1'b0;
      if (nbytes > cfg_capacity) begin
         res.status = cfg_ignore ? fsr_pkg::ST_IGNORED : fsr_pkg::ST_ERROR;
      end else begin
         for (int i = 0; i < ring_count; i++)
            if (ring_addr[(ring_head + i) % SLOTS] == addr) found = 1'b1;
         if (found) begin
            res.status = fsr_pkg::ST_HIT;
         end else begin
            res.status = fsr_pkg::ST_LOADED;
            // table limit: one drop at most, the new entry itself if empty
            if (ring_count + 1 > lim) begin
               retire_oldest();
               ev++;
            end
            if (!(ring_count == 0 && lim == 0)) begin
               slot = (ring_head + ring_count) % SLOTS;
               ring_addr[slot]  = addr;
               ring_bytes[slot] = nbytes;
               ring_count++;
               ring_used = ring_used + nbytes;
            end
            // capacity: evict oldest until the footprint fits
            while (ring_used > cfg_capacity && ring_count > 0) begin
               retire_oldest();
               ev++;
            end
         end
      end
      res.evicted = fsr_pkg::OUT_CNT_W'(ev);
      res.held    = fsr_pkg::OUT_CNT_W'(ring_count);
      res.used    = fsr_pkg::BYTES_W'(ring_used);
      return res;
   endfunction

   function automatic void add_write(input logic [fsr_pkg::CSR_IDX_W-1:0] idx,
                                     input logic [fsr_pkg::BYTES_W-1:0] data);
      plan_row_type row;
      row           = blank_row();
      row.is_write  = 1'b1;
      row.reg_index = idx;
      row.reg_data  = data;
      plan.push_back(row);
   endfunction

   function automatic void add_request(input logic [fsr_pkg::ADDR_W-1:0] addr,
                                       input logic [fsr_pkg::BYTES_W-1:0] nbytes,
                                       input bit typed, input fsr_pkg::status_type st,
                                       input int unsigned ev, input int unsigned held,
                                       input int unsigned used);
      plan_row_type row;
      row              = blank_row();
      row.addr         = addr;
      row.nbytes       = nbytes;
      row.typed        = typed;
      row.want.status  = st;
      row.want.evicted = fsr_pkg::OUT_CNT_W'(ev);
      row.want.held    = fsr_pkg::OUT_CNT_W'(held);
      row.want.used    = fsr_pkg::BYTES_W'(used);
      plan.push_back(row);
   endfunction

   // write one register; valid stays high until the caller lowers it
   task automatic write_reg(input logic [fsr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fsr_pkg::BYTES_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         fsr_pkg::CSR_CAPACITY:    cfg_capacity = data;
         fsr_pkg::CSR_MAX_ENTRIES: cfg_limit    = data[fsr_pkg::MAXE_W-1:0];
         fsr_pkg::CSR_IGNORE:      cfg_ignore   = data[0];
         default: ;
      endcase
   endtask

   // hold start low until every response is back and the block is idle
   task automatic settle_block();
      start <= 1'b0;
      while (pending_outcomes.size() != 0 || busy) @(posedge clock);
   endtask

   // send one request after an optional gap and queue its response
   task automatic issue(input logic [fsr_pkg::ADDR_W-1:0] addr,
                        input logic [fsr_pkg::BYTES_W-1:0] nbytes,
                        input int unsigned gap, input bit typed, input outcome_type want,
                        output outcome_type got);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_func_address <= addr;
      req_func_bytes   <= nbytes;
      do @(posedge clock); while (busy);
      got = predict_residency(addr, nbytes);
      pending_outcomes.push_back(typed ? want : got);
   endtask

   function automatic int unsigned pick_gap(input bit quiet);
      if (quiet || $urandom_range(0, 99) >= 38) return 0;
      return $urandom_range(1, 4);
   endfunction

   // footprints spread around the current capacity
   function automatic logic [fsr_pkg::BYTES_W-1:0] pick_bytes();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 7 && cfg_capacity < MAX_FOOT)
         return fsr_pkg::BYTES_W'($urandom_range(MAX_FOOT, cfg_capacity + 1));
      if (r < 11) return '0;
      if (r < 15)
         return fsr_pkg::BYTES_W'((cfg_capacity < MAX_FOOT) ? cfg_capacity : MAX_FOOT);
      if (r < 19) return fsr_pkg::BYTES_W'($urandom_range(0, MAX_FOOT));
      return fsr_pkg::BYTES_W'($urandom_range(0, cfg_capacity / $urandom_range(1, 6)));
   endfunction

   // rewrite a random subset of the registers, extremes included
   task automatic retune_block();
      int unsigned                 r;
      bit [2:0]                    pick;
      logic [fsr_pkg::BYTES_W-1:0] data;
      pick = 3'($urandom_range(1, 7));
      if (pick[0]) begin
         r = $urandom_range(0, 99);
         if (r < 8)       data = '0;
         else if (r < 14) data = fsr_pkg::BYTES_W'(1);
         else if (r < 22) data = fsr_pkg::BYTES_W'(MAX_FOOT);
         else if (r < 30) data = fsr_pkg::BYTES_W'($urandom_range(0, MAX_FOOT));
         else             data = fsr_pkg::BYTES_W'($urandom_range(16, 8192));
         write_reg(fsr_pkg::CSR_CAPACITY, data);
      end
      if (pick[1]) begin
         r = $urandom_range(0, 99);
         if (r < 8)       data = '0;
         else if (r < 16) data = fsr_pkg::BYTES_W'($urandom_range(17, 31));
         else if (r < 24) data = fsr_pkg::BYTES_W'(16);
         else             data = fsr_pkg::BYTES_W'($urandom_range(1, 16));
         // junk above the field is ignored
         if ($urandom_range(0, 3) == 0)
            data = data | (fsr_pkg::BYTES_W'($urandom) & ~fsr_pkg::BYTES_W'(31));
         write_reg(fsr_pkg::CSR_MAX_ENTRIES, data);
      end
      if (pick[2]) begin
         data = fsr_pkg::BYTES_W'($urandom_range(0, 1));
         if ($urandom_range(0, 3) == 0)
            data = data | (fsr_pkg::BYTES_W'($urandom) & ~fsr_pkg::BYTES_W'(1));
         write_reg(fsr_pkg::CSR_IGNORE, data);
      end
      csr_valid <= 1'b0;
   endtask

   // compare each response with the oldest queued one
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: status %0d evicted %0d held %0d used %0d",
                        rsp_status, rsp_evicted_count, rsp_entries_held, rsp_bytes_used);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status || rsp_evicted_count !== want.evicted ||
                rsp_entries_held !== want.held || rsp_bytes_used !== want.used) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected status %0d evicted %0d held %0d used %0d, %s",
                           want.status, want.evicted, want.held, want.used,
                           $sformatf("got status %0d evicted %0d held %0d used %0d",
                                     rsp_status, rsp_evicted_count, rsp_entries_held,
                                     rsp_bytes_used));
            end
         end
      end
   end

   // abandon a run that hangs
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("[fifo_scratchpad_residency_top] ERROR");
      $finish;
   end

   initial begin
      outcome_type                got;
      outcome_type                none;
      logic [fsr_pkg::ADDR_W-1:0] addr_pool [24];
      int unsigned                pool_size;
      int unsigned                phase_items;
      int unsigned                random_sent;
      logic [fsr_pkg::ADDR_W-1:0] addr;
      bit                         quiet;

      none             = blank_outcome();
      mismatch_count   = 0;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_func_address <= '0;
      req_func_bytes   <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= fsr_pkg::CSR_CAPACITY;
      csr_wdata        <= '0;
      ring_head        = 0;
      ring_count       = 0;
      ring_used        = 0;
      cfg_capacity     = fsr_pkg::CAP_RESET;
      cfg_limit        = fsr_pkg::MAXE_RESET;
      cfg_ignore       = fsr_pkg::IGN_RESET;
      foreach (ring_addr[i]) begin
         ring_addr[i]  = '0;
         ring_bytes[i] = 0;
      end

      // directed plan, starting from the reset settings
      // zero table limit on an empty table: the new entry goes at once
      add_write(fsr_pkg::CSR_MAX_ENTRIES, fsr_pkg::BYTES_W'(0));
      add_request(32'h1234_5678, 21'd50, 1, fsr_pkg::ST_LOADED, 1, 0, 0);
      add_request(32'h0000_0000, 21'd0, 1, fsr_pkg::ST_LOADED, 1, 0, 0);
      add_write(fsr_pkg::CSR_MAX_ENTRIES, fsr_pkg::BYTES_W'(16));
      add_request(32'h0000_0000, 21'd0, 1, fsr_pkg::ST_LOADED, 0, 1, 0);
      add_request(32'h0000_0000, 21'd100, 1, fsr_pkg::ST_HIT, 0, 1, 0);
      add_request(32'hFFFF_FFFF, 21'd4096, 1, fsr_pkg::ST_LOADED, 0, 2, 4096);
      // oversized, ignored
      add_request(32'h0000_0001, 21'd4097, 1, fsr_pkg::ST_IGNORED, 0, 2, 4096);
      add_request(32'h0000_0002, 21'd1048576, 1, fsr_pkg::ST_IGNORED, 0, 2, 4096);
      // capacity overflow evicts both older entries
      add_request(32'h0000_0003, 21'd1, 1, fsr_pkg::ST_LOADED, 2, 1, 1);
      add_write(fsr_pkg::CSR_IGNORE, fsr_pkg::BYTES_W'(0));
      add_request(32'h0000_0004, 21'd1048576, 1, fsr_pkg::ST_ERROR, 0, 1, 1);
      add_request(32'h0000_0003, 21'd4096, 1, fsr_pkg::ST_HIT, 0, 1, 1);
      add_write(fsr_pkg::CSR_MAX_ENTRIES, fsr_pkg::BYTES_W'(2));
      add_request(32'h0000_0005, 21'd10, 1, fsr_pkg::ST_LOADED, 0, 2, 11);
      add_request(32'h0000_0006, 21'd20, 1, fsr_pkg::ST_LOADED, 1, 2, 30);
      // limit lowered below the count: one drop per insertion
      add_write(fsr_pkg::CSR_MAX_ENTRIES, fsr_pkg::BYTES_W'(0));
      add_request(32'h0000_0007, 21'd5, 1, fsr_pkg::ST_LOADED, 1, 2, 25);
      add_request(32'h0000_0006, 21'd0, 1, fsr_pkg::ST_HIT, 0, 2, 25);
      // capacity lowered: residents stay until the next insertion
      add_write(fsr_pkg::CSR_CAPACITY, fsr_pkg::BYTES_W'(8));
      add_request(32'h0000_0006, 21'd9, 1, fsr_pkg::ST_ERROR, 0, 2, 25);
      add_request(32'h0000_0008, 21'd8, 1, fsr_pkg::ST_LOADED, 2, 1, 8);
      // zero capacity still stores a zero-byte function
      add_write(fsr_pkg::CSR_CAPACITY, fsr_pkg::BYTES_W'(0));
      add_write(fsr_pkg::CSR_MAX_ENTRIES, fsr_pkg::BYTES_W'(4));
      add_request(32'h0000_0009, 21'd0, 1, fsr_pkg::ST_LOADED, 1, 1, 0);
      add_request(32'h0000_000B, 21'd1, 1, fsr_pkg::ST_ERROR, 0, 1, 0);
      // table limit above the slot count
      add_write(fsr_pkg::CSR_MAX_ENTRIES, fsr_pkg::BYTES_W'(31));
      add_write(fsr_pkg::CSR_CAPACITY, fsr_pkg::BYTES_W'(MAX_FOOT));
      add_write(fsr_pkg::CSR_IGNORE, fsr_pkg::BYTES_W'(1));
      add_request(32'h0000_0014, 21'd1048576, 1, fsr_pkg::ST_LOADED, 0, 2, 1048576);
      add_request(32'hAAAA_AAAA, 21'h0AAAAA, 0, fsr_pkg::ST_HIT, 0, 0, 0);
      add_request(32'h5555_5555, 21'h055555, 0, fsr_pkg::ST_HIT, 0, 0, 0);
      add_request(32'h0000_0014, 21'd7, 0, fsr_pkg::ST_HIT, 0, 0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed plan
      for (int i = 0; i < plan.size(); i++) begin
         if (plan[i].is_write) begin
            if (i == 0 || !plan[i-1].is_write) settle_block();
            write_reg(plan[i].reg_index, plan[i].reg_data);
            if (i + 1 == plan.size() || !plan[i+1].is_write) csr_valid <= 1'b0;
         end else begin
            issue(plan[i].addr, plan[i].nbytes, pick_gap(1'b0), plan[i].typed,
                  plan[i].want, got);
         end
      end

      // random phases: new settings, then requests over a small address pool
      random_sent = 0;
      while (random_sent < RANDOM_GOAL) begin
         settle_block();
         retune_block();
         pool_size = $urandom_range(4, 24);
         foreach (addr_pool[k]) addr_pool[k] = $urandom;
         if ($urandom_range(0, 3) == 0) addr_pool[0] = '0;
         if ($urandom_range(0, 3) == 0) addr_pool[pool_size-1] = '1;
         phase_items = $urandom_range(20, 80);
         for (int n = 0; n < phase_items; n++) begin
            if ($urandom_range(0, 99) < 85)
               addr = addr_pool[$urandom_range(0, pool_size - 1)];
            else
               addr = $urandom;
            quiet = (random_sent >= 700 && random_sent < 1000);
            issue(addr, pick_bytes(), pick_gap(quiet), 1'b0, none, got);
            random_sent++;
         end
      end

      // drain and allow for the longest search and eviction
      settle_block();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("[fifo_scratchpad_residency_top] OK");
      end else begin
         $display("[fifo_scratchpad_residency_top] ERROR");
      end
      $finish;
   end

endmodule
